/* hw/rtl/bfha_pkg.sv */
// Shared types and constants for the best-fit heap allocator.
package bfha_pkg;

  localparam int unsigned HEAP_FLOOR  = 4096;
  localparam int unsigned HEAP_SIZE_W = 17;

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_NOP   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SMALL   = 2'd1,
    ST_NOFIT   = 2'd2,
    ST_BADFREE = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_A_SCAN,
    S_A_WR1,
    S_A_WR2,
    S_SHDN,
    S_F_RDH,
    S_F_RDN,
    S_F_SCAN,
    S_F_PRQ,
    S_F_PRV,
    S_F_ACT,
    S_F_SHUP,
    S_F_ZH,
    S_F_ZN,
    S_FIN
  } state_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] request_size;
    logic [15:0] data_offset;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] result_offset;
    logic [11:0] free_chunks;
  } rsp_t;

endpackage

/* hw/rtl/best_fit_heap_allocator.sv */
// Best-fit heap allocator metadata engine with free-chunk coalescing.
// Requests enter on in_valid_i/in_ready_o with an opcode (init, allocate,
// free, no-op); each request gives exactly one response on
// out_valid_o/out_ready_i. in_ready_o is high while the sequencer is idle,
// also while an earlier response still waits in the output register.
// cfg_we_i/cfg_data_i write the heap size that the next init applies.
// Chunk headers (one per 4-byte word) and the address-sorted free list live
// in two RAMs with registered reads; each walk steps through them one entry
// a cycle: init sweeps the header RAM and zeroes it over the new heap;
// allocate scans the free list and, when an unsplit chunk leaves the list,
// shifts the later entries down; free reads the chunk and its upper
// neighbor, scans the list, reads the predecessor's header if there is one,
// and shifts the list for the insert or removal.
// The block works on one request at a time and takes the next only in idle.
// After reset both RAMs hold garbage and the heap is empty (limit zero), so
// no header is trusted until the first init; no clearing pass runs at reset.
// A stalled receiver holds the response register; the block finishes the
// next request and waits in its final state until the register drains.
module best_fit_heap_allocator
  import bfha_pkg::*;
#(
  parameter int unsigned MAX_HEAP_BYTES = 65536,
  parameter int unsigned MIN_SPLIT      = 32,
  parameter int unsigned HEADER_BYTES   = 8,
  parameter int unsigned FREE_SLOTS     = 2048
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  req_t                   in_req_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output rsp_t                   out_rsp_o,
  input  logic                   cfg_we_i,
  input  logic [HEAP_SIZE_W-1:0] cfg_data_i
);

  localparam int unsigned HCAP   = (MAX_HEAP_BYTES / 4) * 4;
  localparam int unsigned OFF_W  = $clog2(HCAP + 1);
  localparam int unsigned WDEPTH = HCAP / 4;
  localparam int unsigned WA_W   = $clog2(WDEPTH);
  localparam int unsigned FA_W   = $clog2(FREE_SLOTS);
  localparam int unsigned FC_W   = $clog2(FREE_SLOTS + 1);
  localparam int unsigned HDR    = ((HEADER_BYTES + 3) / 4) * 4;
  localparam int unsigned CW     = ((OFF_W > 17) ? OFF_W : 17) + 1;

  // header RAM: {allocated, size}
  logic [OFF_W:0]   hdr_mem [WDEPTH];
  logic [OFF_W:0]   hdr_rdata_q;
  logic             hdr_we;
  logic [WA_W-1:0]  hdr_waddr, hdr_raddr;
  logic [OFF_W:0]   hdr_wdata;

  logic [OFF_W-1:0] fl_mem [FREE_SLOTS];
  logic [OFF_W-1:0] fl_rdata_q;
  logic             fl_we;
  logic [FA_W-1:0]  fl_waddr, fl_raddr;
  logic [OFF_W-1:0] fl_wdata;

  always_ff @(posedge clk_i) begin
    if (hdr_we) hdr_mem[hdr_waddr] <= hdr_wdata;
    hdr_rdata_q <= hdr_mem[hdr_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (fl_we) fl_mem[fl_waddr] <= fl_wdata;
    fl_rdata_q <= fl_mem[fl_raddr];
  end

  state_e                 state_q, state_d;
  logic                   out_valid_q, out_valid_d;
  rsp_t                   out_rsp_q, out_rsp_d;
  logic [HEAP_SIZE_W-1:0] heap_size_q;
  logic [OFF_W-1:0]       limit_q, limit_d;
  logic [FC_W-1:0]        total_q, total_d;
  logic                   v1_q, v1_d, v2_q, v2_d, sv_q, sv_d, found_q, found_d;
  logic [FC_W-1:0]        i_q, i_d, j_q, j_d, pos_q, pos_d;
  logic [WA_W-1:0]        wc_q, wc_d, wend_q, wend_d;
  status_e                status_q, status_d;
  logic [15:0]            res_q, res_d;
  logic [FA_W-1:0]        idx1_q, idx1_d, idx2_q, idx2_d, bi_q, bi_d, widx_q, widx_d;
  logic [OFF_W-1:0]       off2_q, off2_d, best_q, best_d, boff_q, boff_d;
  logic [OFF_W-1:0]       n_q, n_d, s_q, s_d, nsize_q, nsize_d;
  logic [OFF_W-1:0]       last_q, last_d, psize_q, psize_d;
  logic [CW-1:0]          need_q, need_d, h_q, h_d, nxt_q, nxt_d;
  logic                   split_q, split_d, hok_q, hok_d, nok_q, nok_d;
  logic                   nfree_q, nfree_d, pfree_q, pfree_d;

  logic [OFF_W-1:0] hsz;
  logic             hflag;
  assign hsz   = hdr_rdata_q[OFF_W-1:0];
  assign hflag = hdr_rdata_q[OFF_W];

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  always_comb begin
    logic [CW-1:0]    hs;
    logic [CW-1:0]    tmp;
    logic [OFF_W-1:0] sz;
    state_d     = state_q;
    out_valid_d = out_valid_q;
    out_rsp_d   = out_rsp_q;
    limit_d     = limit_q;
    total_d     = total_q;
    v1_d        = v1_q;
    v2_d        = v2_q;
    sv_d        = sv_q;
    found_d     = found_q;
    i_d         = i_q;
    j_d         = j_q;
    pos_d       = pos_q;
    wc_d        = wc_q;
    wend_d      = wend_q;
    status_d    = status_q;
    res_d       = res_q;
    idx1_d      = idx1_q;
    idx2_d      = idx2_q;
    bi_d        = bi_q;
    widx_d      = widx_q;
    off2_d      = off2_q;
    best_d      = best_q;
    boff_d      = boff_q;
    n_d         = n_q;
    s_d         = s_q;
    nsize_d     = nsize_q;
    last_d      = last_q;
    psize_d     = psize_q;
    need_d      = need_q;
    h_d         = h_q;
    nxt_d       = nxt_q;
    split_d     = split_q;
    hok_d       = hok_q;
    nok_d       = nok_q;
    nfree_d     = nfree_q;
    pfree_d     = pfree_q;
    hdr_we      = 1'b0;
    hdr_waddr   = '0;
    hdr_wdata   = '0;
    hdr_raddr   = '0;
    fl_we       = 1'b0;
    fl_waddr    = '0;
    fl_wdata    = '0;
    fl_raddr    = '0;
    hs          = '0;
    tmp         = '0;
    sz          = '0;

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          status_d = ST_OK;
          res_d    = '0;
          case (in_req_i.opcode)
            OP_INIT: begin
              hs = CW'(heap_size_q);
              if (hs < CW'(HEAP_FLOOR)) hs = CW'(HEAP_FLOOR);
              hs = (hs + CW'(3)) & ~CW'(3);
              if (hs > CW'(HCAP)) hs = CW'(HCAP);
              n_d     = OFF_W'(hs);
              limit_d = OFF_W'(hs);
              wend_d  = WA_W'((hs >> 2) - CW'(1));
              wc_d    = '0;
              state_d = S_INIT;
            end
            OP_ALLOC: begin
              if (in_req_i.request_size == 16'd0) begin
                status_d = ST_SMALL;
                state_d  = S_FIN;
              end else begin
                need_d  = ((CW'(in_req_i.request_size) + CW'(3)) & ~CW'(3)) + CW'(HDR);
                i_d     = '0;
                v1_d    = 1'b0;
                v2_d    = 1'b0;
                found_d = 1'b0;
                state_d = S_A_SCAN;
              end
            end
            OP_FREE: begin
              if (CW'(in_req_i.data_offset) < CW'(HDR)) begin
                status_d = ST_BADFREE;
                state_d  = S_FIN;
              end else begin
                tmp       = CW'(in_req_i.data_offset) - CW'(HDR);
                h_d       = tmp;
                hdr_raddr = tmp[WA_W+1:2];
                hok_d     = (tmp < CW'(limit_q)) && (tmp[1:0] == 2'b00);
                state_d   = S_F_RDH;
              end
            end
            default: state_d = S_FIN;
          endcase
        end
      end

      // zero the header RAM over the new heap, the first word gets the chunk
      S_INIT: begin
        hdr_we    = 1'b1;
        hdr_waddr = wc_q;
        hdr_wdata = (wc_q == '0) ? {1'b0, n_q} : '0;
        wc_d      = wc_q + WA_W'(1);
        if (wc_q == wend_q) begin
          fl_we    = 1'b1;
          fl_waddr = '0;
          fl_wdata = '0;
          total_d  = FC_W'(1);
          state_d  = S_FIN;
        end
      end

      // list read -> header read -> compare, one entry per cycle
      S_A_SCAN: begin
        if (i_q < total_q) begin
          fl_raddr = i_q[FA_W-1:0];
          idx1_d   = i_q[FA_W-1:0];
          v1_d     = 1'b1;
          i_d      = i_q + FC_W'(1);
        end else begin
          v1_d = 1'b0;
        end
        if (v1_q) begin
          hdr_raddr = fl_rdata_q[WA_W+1:2];
          off2_d    = fl_rdata_q;
          idx2_d    = idx1_q;
          v2_d      = 1'b1;
        end else begin
          v2_d = 1'b0;
        end
        if (v2_q) begin
          sz = (off2_q < limit_q && off2_q[1:0] == 2'b00) ? hsz : '0;
          if (CW'(sz) > need_q && (!found_q || sz < best_q)) begin
            found_d = 1'b1;
            best_d  = sz;
            bi_d    = idx2_q;
            boff_d  = off2_q;
          end
        end
        if (i_q >= total_q && !v1_q && !v2_q) begin
          if (!found_q) begin
            status_d = ST_NOFIT;
            state_d  = S_FIN;
          end else begin
            split_d = CW'(best_q) > need_q + CW'(MIN_SPLIT);
            res_d   = 16'(CW'(boff_q) + CW'(HDR));
            state_d = S_A_WR1;
          end
        end
      end

      S_A_WR1: begin
        hdr_we    = 1'b1;
        hdr_waddr = boff_q[WA_W+1:2];
        if (split_q) begin
          hdr_wdata = {1'b1, OFF_W'(need_q)};
          fl_we     = 1'b1;
          fl_waddr  = bi_q;
          fl_wdata  = OFF_W'(CW'(boff_q) + need_q);
          state_d   = S_A_WR2;
        end else begin
          hdr_wdata = {1'b1, best_q};
          j_d       = FC_W'(bi_q) + FC_W'(1);
          sv_d      = 1'b0;
          state_d   = S_SHDN;
        end
      end

      S_A_WR2: begin
        tmp       = CW'(boff_q) + need_q;
        hdr_we    = 1'b1;
        hdr_waddr = tmp[WA_W+1:2];
        hdr_wdata = {1'b0, OFF_W'(CW'(best_q) - need_q)};
        state_d   = S_FIN;
      end

      // close the gap: list[j-1] <= list[j] for j from the start index up
      S_SHDN: begin
        if (j_q < total_q) begin
          fl_raddr = j_q[FA_W-1:0];
          widx_d   = FA_W'(j_q - FC_W'(1));
          sv_d     = 1'b1;
          j_d      = j_q + FC_W'(1);
        end else begin
          sv_d = 1'b0;
        end
        if (sv_q) begin
          fl_we    = 1'b1;
          fl_waddr = widx_q;
          fl_wdata = fl_rdata_q;
        end
        if (j_q >= total_q && !sv_q) begin
          total_d = total_q - FC_W'(1);
          state_d = S_FIN;
        end
      end

      S_F_RDH: begin
        if (!hok_q || hdr_rdata_q == '0 || !hflag) begin
          status_d = ST_BADFREE;
          state_d  = S_FIN;
        end else begin
          tmp       = h_q + CW'(hsz);
          s_d       = hsz;
          nxt_d     = tmp;
          hdr_raddr = tmp[WA_W+1:2];
          nok_d     = (tmp < CW'(limit_q)) && (tmp[1:0] == 2'b00);
          state_d   = S_F_RDN;
        end
      end

      S_F_RDN: begin
        nfree_d = nok_q && hdr_rdata_q != '0 && !hflag;
        nsize_d = hsz;
        i_d     = '0;
        v1_d    = 1'b0;
        found_d = 1'b0;
        state_d = S_F_SCAN;
      end

      // find the first free chunk above the freed one, keep its predecessor
      S_F_SCAN: begin
        if (i_q < total_q && !found_q) begin
          fl_raddr = i_q[FA_W-1:0];
          idx1_d   = i_q[FA_W-1:0];
          v1_d     = 1'b1;
          i_d      = i_q + FC_W'(1);
        end else begin
          v1_d = 1'b0;
        end
        if (v1_q && !found_q) begin
          if (CW'(fl_rdata_q) > h_q) begin
            found_d = 1'b1;
            pos_d   = FC_W'(idx1_q);
          end else begin
            last_d = fl_rdata_q;
          end
        end
        if (found_q || (i_q >= total_q && !v1_q)) begin
          if (!found_q) pos_d = total_q;
          if (pos_d == '0) begin
            pfree_d = 1'b0;
            state_d = S_F_ACT;
          end else begin
            state_d = S_F_PRQ;
          end
        end
      end

      S_F_PRQ: begin
        hdr_raddr = last_q[WA_W+1:2];
        state_d   = S_F_PRV;
      end

      S_F_PRV: begin
        sz      = (last_q < limit_q && last_q[1:0] == 2'b00) ? hsz : '0;
        psize_d = sz;
        pfree_d = (CW'(last_q) + CW'(sz)) == h_q;
        state_d = S_F_ACT;
      end

      S_F_ACT: begin
        if (!pfree_q && !nfree_q) begin
          if (total_q >= FC_W'(FREE_SLOTS)) begin
            status_d = ST_BADFREE;
            state_d  = S_FIN;
          end else begin
            hdr_we    = 1'b1;
            hdr_waddr = h_q[WA_W+1:2];
            hdr_wdata = {1'b0, s_q};
            j_d       = total_q;
            sv_d      = 1'b0;
            state_d   = S_F_SHUP;
          end
        end else if (!pfree_q) begin
          hdr_we    = 1'b1;
          hdr_waddr = h_q[WA_W+1:2];
          hdr_wdata = {1'b0, OFF_W'(CW'(s_q) + CW'(nsize_q))};
          fl_we     = 1'b1;
          fl_waddr  = pos_q[FA_W-1:0];
          fl_wdata  = OFF_W'(h_q);
          state_d   = S_F_ZN;
        end else begin
          hdr_we    = 1'b1;
          hdr_waddr = last_q[WA_W+1:2];
          hdr_wdata = nfree_q ?
                      {1'b0, OFF_W'(CW'(psize_q) + CW'(s_q) + CW'(nsize_q))} :
                      {1'b0, OFF_W'(CW'(psize_q) + CW'(s_q))};
          state_d   = S_F_ZH;
        end
      end

      // open a slot at pos: list[j] <= list[j-1] walking down
      S_F_SHUP: begin
        if (j_q > pos_q) begin
          fl_raddr = FA_W'(j_q - FC_W'(1));
          widx_d   = j_q[FA_W-1:0];
          sv_d     = 1'b1;
          j_d      = j_q - FC_W'(1);
        end else begin
          sv_d = 1'b0;
        end
        if (sv_q) begin
          fl_we    = 1'b1;
          fl_waddr = widx_q;
          fl_wdata = fl_rdata_q;
        end
        if (j_q <= pos_q && !sv_q) begin
          fl_we    = 1'b1;
          fl_waddr = pos_q[FA_W-1:0];
          fl_wdata = OFF_W'(h_q);
          total_d  = total_q + FC_W'(1);
          state_d  = S_FIN;
        end
      end

      S_F_ZH: begin
        hdr_we    = 1'b1;
        hdr_waddr = h_q[WA_W+1:2];
        hdr_wdata = '0;
        state_d   = nfree_q ? S_F_ZN : S_FIN;
      end

      S_F_ZN: begin
        hdr_we    = 1'b1;
        hdr_waddr = nxt_q[WA_W+1:2];
        hdr_wdata = '0;
        if (pfree_q) begin
          // both neighbors merged: the upper chunk leaves the list
          j_d     = pos_q + FC_W'(1);
          sv_d    = 1'b0;
          state_d = S_SHDN;
        end else begin
          state_d = S_FIN;
        end
      end

      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_rsp_d.status        = status_q;
          out_rsp_d.result_offset = res_q;
          out_rsp_d.free_chunks   = 12'(total_q);
          out_valid_d             = 1'b1;
          state_d                 = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      heap_size_q <= HEAP_SIZE_W'(HEAP_FLOOR);
      limit_q     <= '0;
      total_q     <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      sv_q        <= 1'b0;
      found_q     <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      wc_q        <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) heap_size_q <= cfg_data_i;
      limit_q     <= limit_d;
      total_q     <= total_d;
      v1_q        <= v1_d;
      v2_q        <= v2_d;
      sv_q        <= sv_d;
      found_q     <= found_d;
      i_q         <= i_d;
      j_q         <= j_d;
      wc_q        <= wc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_rsp_q <= out_rsp_d;
    pos_q     <= pos_d;
    wend_q    <= wend_d;
    status_q  <= status_d;
    res_q     <= res_d;
    idx1_q    <= idx1_d;
    idx2_q    <= idx2_d;
    bi_q      <= bi_d;
    widx_q    <= widx_d;
    off2_q    <= off2_d;
    best_q    <= best_d;
    boff_q    <= boff_d;
    n_q       <= n_d;
    s_q       <= s_d;
    nsize_q   <= nsize_d;
    last_q    <= last_d;
    psize_q   <= psize_d;
    need_q    <= need_d;
    h_q       <= h_d;
    nxt_q     <= nxt_d;
    split_q   <= split_d;
    hok_q     <= hok_d;
    nok_q     <= nok_d;
    nfree_q   <= nfree_d;
    pfree_q   <= pfree_d;
  end

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= FC_W'(FREE_SLOTS))
    else $error("free list count above capacity");

  a_limit_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (limit_q == '0) || (limit_q[1:0] == 2'b00 && limit_q >= OFF_W'(HEAP_FLOOR)))
    else $error("heap limit not aligned or below minimum");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q != S_IDLE))
    else $error("accepted request did not start");

  a_resp_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_FIN))
    else $error("response raised outside final state");

endmodule

/* tb/sv/tb_best_fit_heap_allocator.sv */
// Self-checking testbench for the best-fit heap allocator with coalescing.
module tb_best_fit_heap_allocator;
  import bfha_pkg::*;

  localparam int unsigned HEAP_CAP   = 65536;
  localparam int unsigned SPLIT_MIN  = 32;
  localparam int unsigned HDR        = 8;
  localparam int unsigned SLOTS      = 2048;
  localparam int unsigned WORDS      = HEAP_CAP / 4 + 1;
  localparam logic [31:0] USED       = 32'h8000_0000;
  localparam int unsigned CYCLE_CAP  = 3_000_000;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  req_t                   in_req = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  rsp_t                   out_rsp;
  logic                   cfg_we = 1'b0;
  logic [HEAP_SIZE_W-1:0] cfg_data = '0;

  best_fit_heap_allocator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_rsp_o   (out_rsp),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data)
  );

  // shadow heap state
  logic [31:0] hdr_mem [0:WORDS-1];
  int unsigned flist [0:SLOTS-1];
  int unsigned ftotal = 0;
  int unsigned hlimit = 0;
  int unsigned hsize  = HEAP_FLOOR;

  rsp_t        pending_rsp [$];
  int unsigned live_ptrs [$];
  int unsigned errors = 0;
  int unsigned sent = 0;
  int unsigned checked = 0;
  int unsigned cycles = 0;
  bit          no_idle = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [31:0] hdr_rd(int unsigned off);
    if (off >= hlimit || off[1:0] != 2'b00) return 32'd0;
    return hdr_mem[off >> 2];
  endfunction

  function automatic void hdr_wr(int unsigned off, logic [31:0] v);
    if (off >= hlimit || off[1:0] != 2'b00) return;
    hdr_mem[off >> 2] = v;
  endfunction

  function automatic void heap_init();
    int unsigned n;
    n = (hsize < HEAP_FLOOR) ? HEAP_FLOOR : hsize;
    n = (n + 3) & ~32'd3;
    if (n > HEAP_CAP) n = HEAP_CAP;
    for (int i = 0; i < WORDS; i++) hdr_mem[i] = 32'd0;
    hlimit = n;
    hdr_wr(0, n);
    flist[0] = 0;
    ftotal = 1;
  endfunction

  function automatic status_e heap_alloc(int unsigned want, output int unsigned ptr);
    int unsigned need, best, best_i, off, s;
    bit found;
    best = 0; best_i = 0; found = 1'b0; ptr = 0;
    if (want < 1) return ST_SMALL;
    need = ((want + 3) & ~32'd3) + HDR;
    for (int unsigned i = 0; i < ftotal; i++) begin
      s = hdr_rd(flist[i]) & ~USED;
      if (s > need && (!found || s < best)) begin
        found = 1'b1; best = s; best_i = i;
      end
    end
    if (!found) return ST_NOFIT;
    off = flist[best_i];
    if (best > need + SPLIT_MIN) begin
      hdr_wr(off, need | USED);
      hdr_wr(off + need, best - need);
      flist[best_i] = off + need;
    end else begin
      hdr_wr(off, best | USED);
      for (int unsigned i = best_i + 1; i < ftotal; i++) flist[i-1] = flist[i];
      ftotal--;
    end
    ptr = off + HDR;
    return ST_OK;
  endfunction

  function automatic status_e heap_release(int unsigned data);
    int unsigned h, s, nxt, nsize, pos, prv;
    logic [31:0] e, ne;
    bit nfree, pfree;
    nsize = 0; prv = 0; pfree = 1'b0;
    if (data < HDR) return ST_BADFREE;
    h = data - HDR;
    e = hdr_rd(h);
    if (e == 0 || !e[31]) return ST_BADFREE;
    s = e & ~USED;
    nxt = h + s;
    ne = hdr_rd(nxt);
    nfree = ne != 0 && !ne[31];
    if (nfree) nsize = ne & ~USED;
    pos = ftotal;
    for (int unsigned i = 0; i < ftotal; i++) begin
      if (flist[i] > h) begin
        pos = i;
        break;
      end
    end
    if (pos > 0) begin
      prv = flist[pos-1];
      pfree = prv + (hdr_rd(prv) & ~USED) == h;
    end
    if (!pfree && !nfree) begin
      if (ftotal >= SLOTS) return ST_BADFREE;
      for (int unsigned i = ftotal; i > pos; i--) flist[i] = flist[i-1];
      flist[pos] = h;
      ftotal++;
      hdr_wr(h, s);
    end else if (!pfree) begin
      hdr_wr(h, s + nsize);
      hdr_wr(nxt, 0);
      flist[pos] = h;
    end else if (!nfree) begin
      hdr_wr(prv, (hdr_rd(prv) & ~USED) + s);
      hdr_wr(h, 0);
    end else begin
      hdr_wr(prv, (hdr_rd(prv) & ~USED) + s + nsize);
      hdr_wr(h, 0);
      hdr_wr(nxt, 0);
      for (int unsigned i = pos + 1; i < ftotal; i++) flist[i-1] = flist[i];
      ftotal--;
    end
    return ST_OK;
  endfunction

  function automatic rsp_t heap_predict(req_t r);
    rsp_t        p;
    int unsigned ptr;
    status_e     st;
    st = ST_OK; ptr = 0;
    case (opcode_e'(r.opcode))
      OP_INIT:  heap_init();
      OP_ALLOC: st = heap_alloc(r.request_size, ptr);
      OP_FREE:  st = heap_release(r.data_offset);
      default:  st = ST_OK;
    endcase
    p.status        = st;
    p.result_offset = ptr[15:0];
    p.free_chunks   = ftotal[11:0];
    return p;
  endfunction

  task automatic report(string what, int unsigned got, int unsigned want);
    errors++;
    $display("mismatch #%0d on %s: got %0d, expected %0d", checked, what, got, want);
  endtask

  // response checker
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (pending_rsp.size() == 0) begin
        report("unexpected response", 1, 0);
      end else begin
        want = pending_rsp.pop_front();
        if (out_rsp.status != want.status)
          report("status", out_rsp.status, want.status);
        if (out_rsp.result_offset != want.result_offset)
          report("result_offset", out_rsp.result_offset, want.result_offset);
        if (out_rsp.free_chunks != want.free_chunks)
          report("free_chunks", out_rsp.free_chunks, want.free_chunks);
      end
      checked++;
    end
  end

  // receiver with random stalls
  initial begin
    int unsigned n;
    @(posedge rst_ni);
    forever begin
      n = no_idle ? 0 : $urandom_range(0, 13);
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!(out_valid && out_ready));
    end
  end

  task automatic send_req(opcode_e op, int unsigned size, int unsigned off);
    int unsigned gap;
    req_t        r;
    rsp_t        p;
    r.opcode = op;
    r.request_size = size[15:0];
    r.data_offset = off[15:0];
    gap = no_idle ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk_i); while (!(in_valid && in_ready));
    p = heap_predict(r);
    pending_rsp.push_back(p);
    sent++;
    if (op == OP_INIT) live_ptrs.delete();
    if (op == OP_ALLOC && p.status == ST_OK) live_ptrs.push_back(p.result_offset);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic set_heap_size(int unsigned v);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= v[HEAP_SIZE_W-1:0];
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    hsize = v & 32'h1FFFF;
  endtask

  task automatic free_live();
    int unsigned k, ptr;
    k = $urandom_range(0, live_ptrs.size() - 1);
    ptr = live_ptrs[k];
    live_ptrs.delete(k);
    send_req(OP_FREE, $urandom, ptr);
  endtask

  task automatic test_before_init();
    send_req(OP_ALLOC, 16, 16'hFFFF);
    send_req(OP_FREE, 16'hFFFF, 8);
    send_req(OP_NOP, 16'hFFFF, 16'hFFFF);
  endtask

  task automatic test_small_heap_edges();
    set_heap_size(0);
    send_req(OP_INIT, 0, 0);
    send_req(OP_ALLOC, 0, 0);
    send_req(OP_ALLOC, 16'hFFFF, 0);
    send_req(OP_ALLOC, 4088, 0);        // need == chunk size: no fit
    send_req(OP_ALLOC, 4087, 0);        // rounds to same
    send_req(OP_ALLOC, 4084, 0);        // unsplit, keeps whole size
    send_req(OP_ALLOC, 1, 0);           // empty list
    send_req(OP_FREE, 0, 8);            // free with empty list
    send_req(OP_FREE, 0, 8);            // double free
    send_req(OP_FREE, 0, 4);            // below header
    send_req(OP_FREE, 0, 10);           // misaligned
    send_req(OP_FREE, 0, 16'hFFFF);     // outside heap
  endtask

  // chunks: 0 (108 B), 108 (12 B), 120 (208 B), 328 (48 B), free tail at 376
  task automatic test_coalescing();
    set_heap_size(4097);
    send_req(OP_INIT, 0, 0);
    send_req(OP_ALLOC, 100, 0);
    send_req(OP_ALLOC, 3, 0);
    send_req(OP_ALLOC, 200, 0);
    send_req(OP_ALLOC, 40, 0);
    send_req(OP_FREE, 0, 8);            // no free neighbor
    send_req(OP_FREE, 0, 328 + 8);      // fourth: merge with free tail
    send_req(OP_FREE, 0, 108 + 8);      // second: merge with previous
    send_req(OP_FREE, 0, 120 + 8);      // third: merge both sides
  endtask

  task automatic test_random(int unsigned count);
    int unsigned roll;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 30 == 0) no_idle = ($urandom_range(0, 3) == 0);
      roll = $urandom_range(0, 99);
      if (roll < 3)
        send_req(OP_INIT, $urandom, $urandom);
      else if (roll < 5)
        send_req(OP_NOP, $urandom, $urandom);
      else if (roll < 10)
        send_req(OP_FREE, $urandom, $urandom);
      else if (roll < 45 && live_ptrs.size() != 0)
        free_live();
      else if (roll < 50)
        send_req(OP_ALLOC, $urandom_range(0, 65535), $urandom);
      else
        send_req(OP_ALLOC, $urandom_range(1, 400), $urandom);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_before_init();
    test_small_heap_edges();
    test_coalescing();
    set_heap_size(17'h1FFFF);           // saturates at the cap
    send_req(OP_INIT, 0, 0);
    test_random(40);
    set_heap_size(12345);
    send_req(OP_INIT, 0, 0);
    test_random(35);
    set_heap_size(65536);
    send_req(OP_INIT, 0, 0);
    test_random(35);
    drain();
    $display("sent %0d requests, checked %0d responses, %0d mismatches", sent, checked, errors);
    $display("covered pre-init access, heap sizing, best-fit split, coalescing, bad frees");
    if (errors == 0 && pending_rsp.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
